// File: design/atdi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atdi_pkg: shared types and constants for the density table interpolator
// Opcodes, status codes, controller states, command and status bundles, and
// the exp2 mantissa constant table built at elaboration.
// ----------------------------------------------------------------------------
package atdi_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int ROW_W       = $clog2(TABLE_DEPTH + 1);
   localparam int LOG_FRAC    = 24;

   localparam logic [31:0] GAS_SCALE   = 32'd788216919;   // 1e5 / R, Q16.16
   localparam logic [31:0] MOLAR_RESET = 32'd124425203;   // 0.02897, Q0.32

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_PZERO = 2'd2,
      ST_TZERO = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      DP_IDLE, DP_TAKE, DP_READ, DP_CMP, DP_FDIV,
      DP_LOG_LD, DP_LOG_NORM, DP_LOG_MI, DP_LOG_SQ, DP_LOG_ST,
      DP_MIX_MUL, DP_MIX_ADD, DP_EXP_INIT, DP_EXP_STEP, DP_EXP_FIN,
      DP_MUL_INIT, DP_MUL_STEP, DP_MUL_NEXT, DP_DIV_INIT, DP_DIV_STEP,
      DP_EMIT
   } dp_op_type;

   typedef enum logic [4:0] {
      C_IDLE, C_RD, C_CMP, C_FDIV,
      C_LOG_LD, C_LOG_NORM, C_LOG_MI, C_LOG_SQ, C_LOG_ST,
      C_MIX_MUL, C_MIX_ADD, C_EXP_INIT, C_EXP_STEP, C_EXP_FIN,
      C_DENS, C_MUL1, C_MUL_NEXT, C_MUL2, C_DIV_INIT, C_DIV, C_FIN
   } ctl_state_type;

   typedef struct packed {
      dp_op_type  op;
      logic       sel;    // log pass: 0 lower row, 1 upper row
      logic [5:0] step;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic row_end;
      logic match;
      logic brk;
      logic pzero;
      logic f_special;
      logic norm_done;
      logic t_zero;
      logic div_sat;
      logic rsp_busy;
   } stat_type;

   typedef logic [30:0] exp_tab_type [LOG_FRAC];

   function automatic logic [63:0] isqrt64(input logic [63:0] xin);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bitv;
      begin
         x    = xin;
         res  = '0;
         bitv = 64'h4000_0000_0000_0000;
         for (int i = 0; i < 32; i++) begin
            if (bitv > x) bitv = bitv >> 2;
         end
         for (int i = 0; i < 32; i++) begin
            if (bitv != 0) begin
               if (x >= res + bitv) begin
                  x   = x - (res + bitv);
                  res = (res >> 1) + bitv;
               end else begin
                  res = res >> 1;
               end
               bitv = bitv >> 2;
            end
         end
         return res;
      end
   endfunction

   // 2^(2^-k), k = 1..24, Q1.30, by chained truncating square roots
   function automatic exp_tab_type exp_tab_build();
      exp_tab_type tab;
      logic [63:0] c;
      begin
         c = 64'd1 << 31;
         for (int k = 0; k < LOG_FRAC; k++) begin
            c      = isqrt64(c << 30);
            tab[k] = c[30:0];
         end
         return tab;
      end
   endfunction

   localparam exp_tab_type EXP_TAB = exp_tab_build();

endpackage

// File: design/atdi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atdi_if: request and response channel interfaces
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface atdi_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic signed [31:0] altitude;
   logic [47:0]        pressure;
   logic [31:0]        temperature;

   modport source (output valid, opcode, altitude, pressure, temperature, input ready);
   modport sink   (input valid, opcode, altitude, pressure, temperature, output ready);
endinterface

interface atdi_rsp_if;
   logic        valid;
   logic        ready;
   logic [47:0] density;
   logic [1:0]  status;

   modport source (output valid, density, status, input ready);
   modport sink   (input valid, density, status, output ready);
endinterface

// File: design/atdi_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atdi_datapath: table storage and arithmetic units
// Row memories, bracket compare, fraction divider, log2/exp2 iteration,
// limb multiplier, density divider and the response register.
// ----------------------------------------------------------------------------
module atdi_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  atdi_pkg::cmd_type     cmd,
   output atdi_pkg::stat_type    stat,
   input  logic [1:0]            req_opcode,
   input  logic signed [31:0]    req_altitude,
   input  logic [47:0]           req_pressure,
   input  logic [31:0]           req_temperature,
   input  logic                  csr_we,
   input  logic [31:0]           csr_wdata,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [47:0]           rsp_density,
   output logic [1:0]            rsp_status
);

   logic signed [31:0] alt_mem [atdi_pkg::TABLE_DEPTH];
   logic [47:0]        p_mem   [atdi_pkg::TABLE_DEPTH];

   logic [atdi_pkg::ROW_W-1:0] row_cnt_ff;
   logic [atdi_pkg::ROW_W-1:0] idx_ff;
   logic [31:0]        molar_ff;
   logic signed [31:0] q_alt_ff;
   logic [31:0]        q_t_ff;
   logic signed [31:0] rd_alt_ff;
   logic [47:0]        rd_p_ff;
   logic signed [31:0] prev_alt_ff;
   logic [47:0]        prev_p_ff;
   logic [47:0]        p0_ff;
   logic [47:0]        p1_ff;
   logic [32:0]        ud_ff;
   logic [32:0]        f_ff;
   logic [32:0]        frem_ff;
   logic [47:0]        lx_ff;
   logic [5:0]         le_ff;
   logic [30:0]        lm_ff;
   logic [23:0]        lfr_ff;
   logic [29:0]        l0_ff;
   logic [29:0]        l1_ff;
   logic [62:0]        mprod_ff;
   logic [29:0]        lsum_ff;
   logic [30:0]        em_ff;
   logic [47:0]        pres_ff;
   logic [95:0]        ma_ff;
   logic [31:0]        mb_ff;
   logic [127:0]       acc_ff;
   logic [31:0]        drem_ff;
   logic [47:0]        dq_ff;
   logic               rsp_valid_ff;
   logic [47:0]        rsp_density_ff;
   logic [1:0]         rsp_status_ff;

   logic signed [32:0] dn_s;
   logic signed [32:0] dd_s;
   logic [32:0]        un;
   logic [32:0]        ud;
   logic signed [31:0] lo;
   logic signed [31:0] hi;
   logic [33:0]        fr2;
   logic [61:0]        sq;
   logic [31:0]        sqs;
   logic [29:0]        mag;
   logic [62:0]        mix_prod;
   logic [4:0]         ek;
   logic [4:0]         ebit;
   logic [61:0]        emul;
   logic [5:0]         en;
   logic [47:0]        em48;
   logic [47:0]        eres;
   logic [31:0]        chunk;
   logic [63:0]        pp;
   logic [6:0]         shamt;
   logic [32:0]        dr2;
   logic [47:0]        dhi;

   always_comb begin
      dn_s = {q_alt_ff[31], q_alt_ff} - {prev_alt_ff[31], prev_alt_ff};
      dd_s = {rd_alt_ff[31], rd_alt_ff} - {prev_alt_ff[31], prev_alt_ff};
      un   = dn_s[32] ? 33'(-dn_s) : 33'(dn_s);
      ud   = dd_s[32] ? 33'(-dd_s) : 33'(dd_s);
      lo   = (prev_alt_ff < rd_alt_ff) ? prev_alt_ff : rd_alt_ff;
      hi   = (prev_alt_ff < rd_alt_ff) ? rd_alt_ff : prev_alt_ff;
      fr2  = {frem_ff, 1'b0};
      sq   = lm_ff * lm_ff;
      sqs  = sq[61:30];
      mag  = (l1_ff >= l0_ff) ? (l1_ff - l0_ff) : (l0_ff - l1_ff);
      mix_prod = mag * f_ff;
      ek   = cmd.step[4:0];
      ebit = 5'(atdi_pkg::LOG_FRAC - 1) - ek;
      emul = em_ff * atdi_pkg::EXP_TAB[ek];
      en   = (lsum_ff[29:24] > 6'd47) ? 6'd47 : lsum_ff[29:24];
      em48 = {17'b0, em_ff};
      eres = (en >= 6'd30) ? (em48 << (en - 6'd30)) : (em48 >> (6'd30 - en));
      chunk = ma_ff[32*cmd.step[1:0] +: 32];
      pp    = chunk * mb_ff;
      shamt = {cmd.step[1:0], 5'b0};
      dr2   = {drem_ff, dq_ff[47]};
      dhi   = acc_ff[127:80];
   end

   always_comb begin
      stat.row_end   = (idx_ff >= row_cnt_ff);
      stat.match     = (rd_alt_ff == q_alt_ff);
      stat.brk       = (idx_ff != '0) && (q_alt_ff >= lo) && (q_alt_ff <= hi);
      stat.pzero     = (prev_p_ff == '0) || (rd_p_ff == '0);
      stat.f_special = (ud == '0) || (un == ud);
      stat.norm_done = lx_ff[47];
      stat.t_zero    = (q_t_ff == '0);
      stat.div_sat   = (dhi >= {16'b0, q_t_ff});
      stat.rsp_busy  = rsp_valid_ff && !rsp_ready;
   end

   // row memories
   always_ff @(posedge clock) begin
      if (cmd.op == atdi_pkg::DP_TAKE && req_opcode == atdi_pkg::OP_APPEND &&
          row_cnt_ff < atdi_pkg::ROW_W'(atdi_pkg::TABLE_DEPTH)) begin
         alt_mem[row_cnt_ff[atdi_pkg::ADDR_W-1:0]] <= req_altitude;
         p_mem[row_cnt_ff[atdi_pkg::ADDR_W-1:0]]   <= req_pressure;
      end
      if (cmd.op == atdi_pkg::DP_READ) begin
         rd_alt_ff <= alt_mem[idx_ff[atdi_pkg::ADDR_W-1:0]];
         rd_p_ff   <= p_mem[idx_ff[atdi_pkg::ADDR_W-1:0]];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff   <= '0;
         idx_ff       <= '0;
         molar_ff     <= atdi_pkg::MOLAR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) molar_ff <= csr_wdata;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (cmd.op)
            atdi_pkg::DP_TAKE: begin
               case (req_opcode)
                  atdi_pkg::OP_CLEAR: row_cnt_ff <= '0;
                  atdi_pkg::OP_APPEND: begin
                     if (row_cnt_ff < atdi_pkg::ROW_W'(atdi_pkg::TABLE_DEPTH))
                        row_cnt_ff <= row_cnt_ff + 1'b1;
                  end
                  atdi_pkg::OP_QUERY: idx_ff <= '0;
                  default: ;
               endcase
            end
            atdi_pkg::DP_CMP:  idx_ff <= idx_ff + 1'b1;
            atdi_pkg::DP_EMIT: rsp_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   // payload
   always_ff @(posedge clock) begin
      case (cmd.op)
         atdi_pkg::DP_TAKE: begin
            q_alt_ff <= req_altitude;
            q_t_ff   <= req_temperature;
         end
         atdi_pkg::DP_CMP: begin
            prev_alt_ff <= rd_alt_ff;
            prev_p_ff   <= rd_p_ff;
            p0_ff       <= prev_p_ff;
            p1_ff       <= rd_p_ff;
            pres_ff     <= rd_p_ff;
            ud_ff       <= ud;
            frem_ff     <= un;
            f_ff        <= (ud != '0 && un == ud) ? {1'b1, 32'b0} : '0;
         end
         atdi_pkg::DP_FDIV: begin
            if (fr2 >= {1'b0, ud_ff}) begin
               frem_ff <= 33'(fr2 - {1'b0, ud_ff});
               f_ff    <= {f_ff[31:0], 1'b1};
            end else begin
               frem_ff <= fr2[32:0];
               f_ff    <= {f_ff[31:0], 1'b0};
            end
         end
         atdi_pkg::DP_LOG_LD: begin
            lx_ff <= cmd.sel ? p1_ff : p0_ff;
            le_ff <= 6'd47;
         end
         atdi_pkg::DP_LOG_NORM: begin
            if (!lx_ff[47]) begin
               lx_ff <= {lx_ff[46:0], 1'b0};
               le_ff <= le_ff - 1'b1;
            end
         end
         atdi_pkg::DP_LOG_MI: begin
            lm_ff  <= lx_ff[47:17];
            lfr_ff <= '0;
         end
         atdi_pkg::DP_LOG_SQ: begin
            lfr_ff <= {lfr_ff[22:0], sqs[31]};
            lm_ff  <= sqs[31] ? sqs[31:1] : sqs[30:0];
         end
         atdi_pkg::DP_LOG_ST: begin
            if (cmd.sel) l1_ff <= {le_ff, lfr_ff};
            else         l0_ff <= {le_ff, lfr_ff};
         end
         atdi_pkg::DP_MIX_MUL: mprod_ff <= mix_prod;
         atdi_pkg::DP_MIX_ADD: begin
            lsum_ff <= (l1_ff >= l0_ff) ? (l0_ff + mprod_ff[61:32])
                                        : (l0_ff - mprod_ff[61:32]);
         end
         atdi_pkg::DP_EXP_INIT: em_ff <= 31'h4000_0000;
         atdi_pkg::DP_EXP_STEP: begin
            if (lsum_ff[ebit]) em_ff <= emul[60:30];
         end
         atdi_pkg::DP_EXP_FIN: pres_ff <= eres;
         atdi_pkg::DP_MUL_INIT: begin
            acc_ff <= '0;
            ma_ff  <= {48'b0, pres_ff};
            mb_ff  <= molar_ff;
         end
         atdi_pkg::DP_MUL_STEP: acc_ff <= acc_ff + (128'(pp) << shamt);
         atdi_pkg::DP_MUL_NEXT: begin
            ma_ff  <= acc_ff[95:0];
            mb_ff  <= atdi_pkg::GAS_SCALE;
            acc_ff <= '0;
         end
         atdi_pkg::DP_DIV_INIT: begin
            if (dhi >= {16'b0, q_t_ff}) begin
               dq_ff <= '1;
            end else begin
               drem_ff <= dhi[31:0];
               dq_ff   <= acc_ff[79:32];
            end
         end
         atdi_pkg::DP_DIV_STEP: begin
            if (dr2 >= {1'b0, q_t_ff}) begin
               drem_ff <= 32'(dr2 - {1'b0, q_t_ff});
               dq_ff   <= {dq_ff[46:0], 1'b1};
            end else begin
               drem_ff <= dr2[31:0];
               dq_ff   <= {dq_ff[46:0], 1'b0};
            end
         end
         atdi_pkg::DP_EMIT: begin
            rsp_density_ff <= (cmd.code == atdi_pkg::ST_OK) ? dq_ff : '0;
            rsp_status_ff  <= cmd.code;
         end
         default: ;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_density = rsp_density_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

// File: design/atdi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atdi_ctrl: sequencing state machine
// Walks the rows, steps the log, exp, multiply and divide iterations and
// hands the result to the response register.
// ----------------------------------------------------------------------------
module atdi_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_opcode,
   output logic                  req_ready,
   input  atdi_pkg::stat_type    stat,
   output atdi_pkg::cmd_type     cmd
);

   atdi_pkg::ctl_state_type state_ff, state_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 sel_ff, sel_in;
   atdi_pkg::status_type code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= atdi_pkg::C_IDLE;
         cnt_ff   <= '0;
         sel_ff   <= 1'b0;
         code_ff  <= atdi_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
         code_ff  <= code_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + 1'b1;
      sel_in   = sel_ff;
      code_in  = code_ff;
      case (state_ff)
         atdi_pkg::C_IDLE: begin
            if (req_valid && req_opcode == atdi_pkg::OP_QUERY) state_in = atdi_pkg::C_RD;
         end
         atdi_pkg::C_RD: begin
            if (stat.row_end) begin
               code_in  = atdi_pkg::ST_RANGE;
               state_in = atdi_pkg::C_FIN;
            end else begin
               state_in = atdi_pkg::C_CMP;
            end
         end
         atdi_pkg::C_CMP: begin
            sel_in = 1'b0;
            cnt_in = '0;
            if (stat.match) begin
               state_in = atdi_pkg::C_DENS;
            end else if (stat.brk) begin
               if (stat.pzero) begin
                  code_in  = atdi_pkg::ST_PZERO;
                  state_in = atdi_pkg::C_FIN;
               end else if (stat.f_special) begin
                  state_in = atdi_pkg::C_LOG_LD;
               end else begin
                  state_in = atdi_pkg::C_FDIV;
               end
            end else begin
               state_in = atdi_pkg::C_RD;
            end
         end
         atdi_pkg::C_FDIV:     if (cnt_ff == 6'd31) state_in = atdi_pkg::C_LOG_LD;
         atdi_pkg::C_LOG_LD:   state_in = atdi_pkg::C_LOG_NORM;
         atdi_pkg::C_LOG_NORM: if (stat.norm_done) state_in = atdi_pkg::C_LOG_MI;
         atdi_pkg::C_LOG_MI: begin
            cnt_in   = '0;
            state_in = atdi_pkg::C_LOG_SQ;
         end
         atdi_pkg::C_LOG_SQ: begin
            if (cnt_ff == 6'(atdi_pkg::LOG_FRAC - 1)) state_in = atdi_pkg::C_LOG_ST;
         end
         atdi_pkg::C_LOG_ST: begin
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = atdi_pkg::C_LOG_LD;
            end else begin
               state_in = atdi_pkg::C_MIX_MUL;
            end
         end
         atdi_pkg::C_MIX_MUL: state_in = atdi_pkg::C_MIX_ADD;
         atdi_pkg::C_MIX_ADD: state_in = atdi_pkg::C_EXP_INIT;
         atdi_pkg::C_EXP_INIT: begin
            cnt_in   = '0;
            state_in = atdi_pkg::C_EXP_STEP;
         end
         atdi_pkg::C_EXP_STEP: begin
            if (cnt_ff == 6'(atdi_pkg::LOG_FRAC - 1)) state_in = atdi_pkg::C_EXP_FIN;
         end
         atdi_pkg::C_EXP_FIN: state_in = atdi_pkg::C_DENS;
         atdi_pkg::C_DENS: begin
            cnt_in = '0;
            if (stat.t_zero) begin
               code_in  = atdi_pkg::ST_TZERO;
               state_in = atdi_pkg::C_FIN;
            end else begin
               code_in  = atdi_pkg::ST_OK;
               state_in = atdi_pkg::C_MUL1;
            end
         end
         atdi_pkg::C_MUL1:     if (cnt_ff == 6'd2) state_in = atdi_pkg::C_MUL_NEXT;
         atdi_pkg::C_MUL_NEXT: begin
            cnt_in   = '0;
            state_in = atdi_pkg::C_MUL2;
         end
         atdi_pkg::C_MUL2:     if (cnt_ff == 6'd2) state_in = atdi_pkg::C_DIV_INIT;
         atdi_pkg::C_DIV_INIT: begin
            cnt_in   = '0;
            state_in = stat.div_sat ? atdi_pkg::C_FIN : atdi_pkg::C_DIV;
         end
         atdi_pkg::C_DIV:      if (cnt_ff == 6'd47) state_in = atdi_pkg::C_FIN;
         atdi_pkg::C_FIN:      if (!stat.rsp_busy) state_in = atdi_pkg::C_IDLE;
         default:              state_in = atdi_pkg::C_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = atdi_pkg::DP_IDLE;
      cmd.sel   = sel_ff;
      cmd.step  = cnt_ff;
      cmd.code  = code_ff;
      case (state_ff)
         atdi_pkg::C_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = atdi_pkg::DP_TAKE;
         end
         atdi_pkg::C_RD:       cmd.op = atdi_pkg::DP_READ;
         atdi_pkg::C_CMP:      cmd.op = atdi_pkg::DP_CMP;
         atdi_pkg::C_FDIV:     cmd.op = atdi_pkg::DP_FDIV;
         atdi_pkg::C_LOG_LD:   cmd.op = atdi_pkg::DP_LOG_LD;
         atdi_pkg::C_LOG_NORM: cmd.op = atdi_pkg::DP_LOG_NORM;
         atdi_pkg::C_LOG_MI:   cmd.op = atdi_pkg::DP_LOG_MI;
         atdi_pkg::C_LOG_SQ:   cmd.op = atdi_pkg::DP_LOG_SQ;
         atdi_pkg::C_LOG_ST:   cmd.op = atdi_pkg::DP_LOG_ST;
         atdi_pkg::C_MIX_MUL:  cmd.op = atdi_pkg::DP_MIX_MUL;
         atdi_pkg::C_MIX_ADD:  cmd.op = atdi_pkg::DP_MIX_ADD;
         atdi_pkg::C_EXP_INIT: cmd.op = atdi_pkg::DP_EXP_INIT;
         atdi_pkg::C_EXP_STEP: cmd.op = atdi_pkg::DP_EXP_STEP;
         atdi_pkg::C_EXP_FIN:  cmd.op = atdi_pkg::DP_EXP_FIN;
         atdi_pkg::C_DENS:     cmd.op = atdi_pkg::DP_MUL_INIT;
         atdi_pkg::C_MUL1:     cmd.op = atdi_pkg::DP_MUL_STEP;
         atdi_pkg::C_MUL_NEXT: cmd.op = atdi_pkg::DP_MUL_NEXT;
         atdi_pkg::C_MUL2:     cmd.op = atdi_pkg::DP_MUL_STEP;
         atdi_pkg::C_DIV_INIT: cmd.op = atdi_pkg::DP_DIV_INIT;
         atdi_pkg::C_DIV:      cmd.op = atdi_pkg::DP_DIV_STEP;
         atdi_pkg::C_FIN: begin
            if (!stat.rsp_busy) cmd.op = atdi_pkg::DP_EMIT;
         end
         default: ;
      endcase
   end

endmodule

// File: design/atdi_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atmos_density_table_interp: altitude/pressure table with density lookup
// Clear, append and query beats on req_ch; one density beat per query.
// ----------------------------------------------------------------------------
// Usage
//   req_ch carries opcode, altitude, pressure and temperature. Clear and
//   append beats give no response; appends beyond 64 rows are dropped.
//   A query beat gives one rsp_ch beat (density, status).
//   csr_we/csr_wdata write the molar mass register; write it while idle.
// Sequencing
//   A query walks the rows, each row a registered memory read, then a
//   compare. An exact hit adds two 3-step limb multiplies and a 48-step
//   divide. A bracketed point adds a 32-step fraction divide, two log2
//   passes of up to 47 normalize steps plus 24 squaring steps each, and
//   24 exp2 steps.
//   One query is in flight at a time; req_ch.ready is high only when idle.
// Reset and stalls
//   Reset empties the table, restores the molar mass and drops any pending
//   response. The response waits in an output register; while rsp_ch stalls
//   the next beat is still taken, and a following query holds at its end.
// ----------------------------------------------------------------------------
module atmos_density_table_interp (
   input  logic          clock,
   input  logic          reset,
   atdi_req_if.sink      req_ch,
   atdi_rsp_if.source    rsp_ch,
   input  logic          csr_we,
   input  logic [31:0]   csr_wdata
);

   atdi_pkg::cmd_type  cmd;
   atdi_pkg::stat_type stat;

   atdi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ch.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   atdi_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_ch.opcode),
      .req_altitude    (req_ch.altitude),
      .req_pressure    (req_ch.pressure),
      .req_temperature (req_ch.temperature),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_density     (rsp_ch.density),
      .rsp_status      (rsp_ch.status)
   );

endmodule

// File: test/atdi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atdi_checker: density lookup predictor and response scoreboard
// Watches the request, response and CSR ports, keeps its own copy of the
// altitude/pressure table and molar mass, predicts each query's density and
// status, and compares every response beat with the oldest prediction.
// ----------------------------------------------------------------------------
module atdi_checker
   import atdi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   atdi_req_if         req,
   atdi_rsp_if         rsp,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          results_seen
);

   typedef struct packed {
      logic [47:0] density;
      status_type  status;
   } density_beat_t;

   density_beat_t      density_due[$];
   logic [31:0]        molar;
   logic signed [31:0] alt_tab [TABLE_DEPTH];
   logic [47:0]        pres_tab [TABLE_DEPTH];
   int                 rows;
   logic [63:0]        root_step [1:LOG_FRAC];   // 2^(2^-k), Q2.30

   function automatic logic [63:0] int_root(logic [63:0] xin);
      logic [63:0] x = xin;
      logic [63:0] r = '0;
      logic [63:0] b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   initial begin
      logic [63:0] c;
      c = 64'd1 << 31;
      for (int k = 1; k <= LOG_FRAC; k++) begin
         c = int_root(c << 30);
         root_step[k] = c;
      end
   end

   // log2 of a nonzero raw pressure, Q6.24
   function automatic logic [29:0] log2_q24(logic [47:0] x);
      int          e;
      logic [63:0] m;
      logic [23:0] fr;
      e  = 47;
      fr = '0;
      while (x[e] == 1'b0 && e > 0) e--;
      m = (e >= 30) ? ({16'd0, x} >> (e - 30)) : ({16'd0, x} << (30 - e));
      for (int k = 0; k < LOG_FRAC; k++) begin
         m  = (m * m) >> 30;
         fr = {fr[22:0], 1'b0};
         if (m >= 64'h8000_0000) begin
            fr[0] = 1'b1;
            m     = m >> 1;
         end
      end
      return {e[5:0], fr};
   endfunction

   function automatic logic [47:0] pow2_q24(logic [29:0] lq);
      int          n;
      logic [63:0] m;
      logic [63:0] r;
      n = lq[29:24];
      m = 64'd1 << 30;
      for (int k = 1; k <= LOG_FRAC; k++)
         if (lq[LOG_FRAC - k]) m = (m * root_step[k]) >> 30;
      if (n > 47) n = 47;
      r = (n >= 30) ? (m << (n - 30)) : (m >> (30 - n));
      return (r > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : r[47:0];
   endfunction

   function automatic logic [47:0] density_calc(logic [47:0] p, logic [31:0] t);
      logic [127:0] prod;
      logic [127:0] q;
      prod = 128'(p) * 128'(molar) * 128'(GAS_SCALE);
      q    = (prod >> 32) / 128'(t);
      return (q > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : q[47:0];
   endfunction

   function automatic status_type pressure_at(logic signed [31:0] alt,
                                              output logic [47:0] p);
      logic signed [31:0] a0, a1, lo, hi;
      longint             dn, dd;
      logic [63:0]        un, ud, f, mag;
      logic [29:0]        l0, l1;
      p = '0;
      for (int i = 0; i < rows; i++) begin
         if (alt_tab[i] == alt) begin
            p = pres_tab[i];
            return ST_OK;
         end
         if (i == 0) continue;
         a0 = alt_tab[i-1];
         a1 = alt_tab[i];
         lo = (a0 < a1) ? a0 : a1;
         hi = (a0 < a1) ? a1 : a0;
         if (alt >= lo && alt <= hi) begin
            if (pres_tab[i-1] == 0 || pres_tab[i] == 0) return ST_PZERO;
            dn  = longint'(alt) - longint'(a0);
            dd  = longint'(a1) - longint'(a0);
            un  = (dn < 0) ? -dn : dn;
            ud  = (dd < 0) ? -dd : dd;
            f   = (ud == 0) ? 64'd0 : (un << 32) / ud;
            l0  = log2_q24(pres_tab[i-1]);
            l1  = log2_q24(pres_tab[i]);
            mag = (l1 >= l0) ? 64'(l1 - l0) : 64'(l0 - l1);
            mag = (mag * f) >> 32;
            p   = pow2_q24((l1 >= l0) ? 30'(l0 + mag) : 30'(l0 - mag));
            return ST_OK;
         end
      end
      return ST_RANGE;
   endfunction

   always @(posedge clock) begin
      density_beat_t want, got;
      logic [47:0]   p;
      status_type    st;
      if (reset) begin
         molar = MOLAR_RESET;
         rows  = 0;
         density_due.delete();
         fail_count   = 0;
         results_seen = 0;
      end else begin
         // response first: it belongs to an earlier query
         if (rsp.valid && rsp.ready) begin
            results_seen++;
            got.density = rsp.density;
            got.status  = status_type'(rsp.status);
            if (density_due.size() == 0) begin
               $error("density beat with no query outstanding: %h/%0d",
                      got.density, got.status);
               fail_count++;
            end else begin
               want = density_due.pop_front();
               if (got.density !== want.density) begin
                  $error("density: expected %h, got %h", want.density, got.density);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready) begin
            case (req.opcode)
               OP_CLEAR: rows = 0;
               OP_APPEND: begin
                  if (rows < TABLE_DEPTH) begin
                     alt_tab[rows]  = req.altitude;
                     pres_tab[rows] = req.pressure;
                     rows++;
                  end
               end
               OP_QUERY: begin
                  st = pressure_at(req.altitude, p);
                  if (st == ST_OK && req.temperature == 0) st = ST_TZERO;
                  want.status  = st;
                  want.density = (st == ST_OK && molar != 0)
                                 ? density_calc(p, req.temperature) : '0;
                  density_due.push_back(want);
               end
               default: ;   // unused opcode: no effect
            endcase
         end
         if (csr_we) molar = csr_wdata;
      end
      pending = density_due.size();
   end

endmodule

// File: test/tb_atmos_density_table_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_atmos_density_table_interp: testbench top for the density interpolator
// Builds tables of altitude/pressure rows and queries them across several
// molar mass settings, with random idling on both channels, a long response
// stall, and a drain pause. Prediction and checking live in atdi_checker.
// ----------------------------------------------------------------------------
module tb_atmos_density_table_interp;
   import atdi_pkg::*;

   localparam int ITEM_TARGET = 1700;
   localparam int IDLE_LIMIT  = 20000;   // cycles with no beat on any port
   localparam int DRAIN_WAIT  = 600;
   localparam int LONG_HOLD   = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;

   atdi_req_if req_ch();
   atdi_rsp_if rsp_ch();

   int  fail_count, pending, results_seen;
   int  items, idle_cycles, settings_used;
   bit  quiet;              // no idling in the final stretch
   bit  long_hold_req;      // receiver picks this up and holds off
   int  hold_left, stall_left;
   int  row_alts[$];        // mirror of appended altitudes, for query aiming

   atmos_density_table_interp DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   atdi_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .pending      (pending),
      .results_seen (results_seen)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.opcode      = OP_CLEAR;
      req_ch.altitude    = '0;
      req_ch.pressure    = '0;
      req_ch.temperature = '0;
      rsp_ch.ready       = 1'b0;
   end

   // Watchdog: nothing accepted for too long means a hung block.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("atmos_density_table_interp verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Response side: random stall bursts, plus one long hold on request.
   initial begin
      hold_left  = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // One request beat; valid stays high on return so back-to-back beats
   // never drop it. A random gap may come first.
   task automatic put_beat(logic [1:0] op, logic [31:0] alt, logic [47:0] pres,
                           logic [31:0] temp);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= op;
      req_ch.altitude    <= alt;
      req_ch.pressure    <= pres;
      req_ch.temperature <= temp;
      @(posedge clock iff req_ch.ready);
      if (op != 2'd3) items++;
      if (op == OP_CLEAR) row_alts.delete();
      if (op == OP_APPEND && row_alts.size() < TABLE_DEPTH) row_alts.push_back(alt);
   endtask

   // Drop valid, let every outstanding query come back, then let the block settle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_molar(logic [31:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [47:0] pick_pressure();
      case ($urandom_range(0, 14))
         0:       return '0;
         1:       return 48'hFFFF_FFFF_FFFF;
         2:       return 48'($urandom_range(1, 1000));
         3, 4:    return {$urandom_range(0, 65535), $urandom};
         default: return {14'd0, $urandom_range(0, 3), $urandom};   // 0..4 bar
      endcase
   endfunction

   function automatic logic [31:0] pick_temp();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom_range(1, 255);
         3:       return $urandom;
         default: return $urandom_range(150 << 16, 400 << 16);
      endcase
   endfunction

   // Query altitude: mostly inside a bracketing pair, some exact, some anywhere.
   function automatic logic [31:0] pick_alt();
      int     i;
      longint a0, a1;
      if (row_alts.size() < 2 || $urandom_range(0, 9) < 2) return $urandom;
      i = $urandom_range(1, row_alts.size() - 1);
      if ($urandom_range(0, 9) < 3) return row_alts[i];
      a0 = row_alts[i-1];
      a1 = row_alts[i];
      return 32'(a0 + ((a1 - a0) * longint'($urandom_range(0, 1000))) / 1000);
   endfunction

   // Usually clear first, build a table in one of several altitude layouts, then query it.
   task automatic table_session(bit with_hold);
      int n, mode, base, stride;
      int alts[$];
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 68) : $urandom_range(2, 12);
      mode   = $urandom_range(0, 3);
      base   = $urandom;
      stride = $urandom_range(1, 65536 * 4);
      for (int i = 0; i < n; i++)
         alts.push_back((mode == 2) ? base + i * stride : $urandom);
      if (mode == 0) alts.sort();
      if (mode == 1) alts.rsort();
      if ($urandom_range(0, 7) != 0) put_beat(OP_CLEAR, $urandom, pick_pressure(), $urandom);
      foreach (alts[i]) put_beat(OP_APPEND, alts[i], pick_pressure(), $urandom);
      if (with_hold) long_hold_req = 1'b1;
      repeat ($urandom_range(2, 8)) begin
         if ($urandom_range(0, 24) == 0) put_beat(2'd3, $urandom, pick_pressure(), $urandom);
         put_beat(OP_QUERY, pick_alt(), pick_pressure(), pick_temp());
      end
   endtask

   initial begin
      logic [31:0] molar_plan [4];
      items         = 0;
      settings_used = 1;       // reset value of the molar mass
      quiet         = 1'b0;
      long_hold_req = 1'b0;
      molar_plan    = '{32'h0, 32'hFFFF_FFFF, $urandom, MOLAR_RESET};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, extreme rows, zero pressures, zero temperature.
      put_beat(OP_CLEAR,  0, 0, 0);
      put_beat(OP_QUERY,  0, 0, 288 << 16);                        // empty: out of range
      put_beat(OP_APPEND, 32'h8000_0000, 48'hFFFF_FFFF_FFFF, 0);
      put_beat(OP_APPEND, 0, 0, 0);
      put_beat(OP_APPEND, 32'h7FFF_FFFF, 1, 0);
      put_beat(OP_QUERY,  32'h8000_0000, 0, 32'hFFFF_FFFF);       // exact, max pressure
      put_beat(OP_QUERY,  0, 0, 288 << 16);                        // exact on zero row
      put_beat(OP_QUERY,  -5, 0, 0);                               // zero-pressure pair wins
      put_beat(OP_QUERY,  100, 0, 288 << 16);                      // zero-pressure pair
      put_beat(OP_QUERY,  32'h7FFF_FFFF, 0, 0);                    // zero temperature
      put_beat(2'd3,      0, 0, 0);                                // unused opcode
      put_beat(OP_CLEAR,  0, 0, 0);
      put_beat(OP_APPEND, 0, 48'h1_0000_0000, 0);                  // 1 bar at sea level
      put_beat(OP_APPEND, 10 << 16, 48'h0_4CCC_CCCD, 0);           // 0.3 bar at 10 km
      put_beat(OP_QUERY,  5 << 16, 0, 288 << 16);                  // interpolated
      put_beat(OP_QUERY,  -1, 0, 288 << 16);                       // below range
      put_beat(OP_QUERY,  (10 << 16) + 1, 0, 288 << 16);           // above range
      put_beat(OP_QUERY,  3 << 16, 0, 1);                          // tiny temperature saturates

      // Random phases, one molar mass setting each.
      for (int ph = 0; ph < 4; ph++) begin
         write_molar(molar_plan[ph]);
         while (items < (ph + 1) * ITEM_TARGET / 4) begin
            if (ph == 3 && items > ITEM_TARGET - 150) quiet = 1'b1;
            table_session(ph == 1 && items < ITEM_TARGET / 4 + 40);
            if (ph == 0 && items > ITEM_TARGET / 8 && items < ITEM_TARGET / 8 + 20) begin
               // sender waits for every outstanding density beat
               req_ch.valid <= 1'b0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
         end
      end

      drain();
      $display("Covered %0d request beats and %0d density beats over %0d molar settings.",
               items, results_seen, settings_used);
      if (fail_count == 0 && pending == 0) begin
         $display("atmos_density_table_interp verification clean");
      end else begin
         $display("atmos_density_table_interp verification failed");
      end
      $finish;
   end

endmodule
